// ===== design/mdrb_pkg.sv =====
// Package of the motor driver register block: request kinds, register
// addresses, reset values, fixed identification words and the reset
// contents of the coil-pattern table. No dependencies.
package mdrb_pkg;

	// Request kinds. The fourth code is a no-op request.
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	// Register addresses.
	localparam logic [7:0] ADDR_PID       = 8'h00;
	localparam logic [7:0] ADDR_VID       = 8'h01;
	localparam logic [7:0] ADDR_VERSION   = 8'h02;
	localparam logic [7:0] ADDR_STEP_EN   = 8'h1A;
	localparam logic [7:0] ADDR_STEP_DIS  = 8'h1B;
	localparam logic [7:0] ADDR_STEPS     = 8'h1C;
	localparam logic [7:0] ADDR_INTERVAL  = 8'h1D;
	localparam logic [7:0] ADDR_TBL_LEN   = 8'h20;
	localparam logic [7:0] ADDR_TBL_DATA  = 8'h21;
	localparam logic [7:0] ADDR_DUTY      = 8'h82;
	localparam logic [7:0] ADDR_PRESCALE  = 8'h84;
	localparam logic [7:0] ADDR_COIL_A    = 8'hA1;
	localparam logic [7:0] ADDR_COIL_B    = 8'hA5;
	localparam logic [7:0] ADDR_COIL_ALL  = 8'hAA;

	// Identification words.
	localparam logic [15:0] PRODUCT_ID = 16'h0006;
	localparam logic [15:0] VENDOR_ID  = 16'h2886;
	localparam logic [7:0]  FW_VERSION = 8'h04;

	// Direction codes; any other value holds the table position.
	localparam logic [7:0] DIR_CCW = 8'd0;
	localparam logic [7:0] DIR_CW  = 8'd1;

	// Reset values.
	localparam logic [7:0]  DIVISOR_RESET    = 8'd100;
	localparam logic [15:0] PULSES_RESET     = 16'd255;
	localparam logic [3:0]  COIL_RESET       = 4'hF;
	localparam logic [2:0]  PRESCALE_DEFAULT = 3'd3;
	localparam logic [2:0]  PRESCALE_MIN     = 3'd1;
	localparam logic [2:0]  PRESCALE_MAX     = 3'd5;
	localparam logic [7:0]  PATTERN_LEN_RESET = 8'd8;
	localparam logic [7:0]  DUTY_FULL        = 8'hFF;

	// The interval is given in units of 40. The quotient is taken as
	// (interval >> 3) / 5, and the divide by 5 as a multiply by
	// ceil(2^18 / 5) and a shift by 18, exact for 13-bit operands.
	localparam int unsigned  DIV_PRE_SHIFT = 3;
	localparam logic [15:0]  DIV_RECIP     = 16'd52429;
	localparam int unsigned  DIV_POST_SHIFT = 18;

	// Eight-phase half-step sequence that unwritten table entries read as after reset.
	localparam logic [3:0] HALF_STEP [8] = '{
		4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
	};

	// Reset content of a table entry.
	function automatic logic [3:0] pattern_reset_at(input logic [7:0] idx);
		logic [3:0] val;
		val = 4'h0;
		if (idx < 8'd8) begin
			val = HALF_STEP[idx[2:0]];
		end
		return val;
	endfunction

endpackage

// ===== design/mdrb_cmd_if.sv =====
// Request channel of the motor driver register block: valid/ready
// handshake carrying the request kind, register address and write data.
// Depends on nothing.
interface mdrb_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] reg_addr;
	logic [7:0] data_lo;
	logic [7:0] data_hi;

	modport source (output valid, kind, reg_addr, data_lo, data_hi, input ready);
	modport sink   (input valid, kind, reg_addr, data_lo, data_hi, output ready);
endinterface

// ===== design/mdrb_rsp_if.sv =====
// Result channel of the motor driver register block: valid/ready
// handshake carrying read data and the driver output settings.
// Depends on nothing.
interface mdrb_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_lo;
	logic [7:0]  read_hi;
	logic [3:0]  coils;
	logic [7:0]  duty_a;
	logic [7:0]  duty_b;
	logic [2:0]  pwm_prescale;
	logic        fast_step_period;
	logic        step_timer_on;
	logic [15:0] steps_left;

	modport source (
		output valid, read_lo, read_hi, coils, duty_a, duty_b, pwm_prescale,
		       fast_step_period, step_timer_on, steps_left,
		input  ready
	);
	modport sink (
		input  valid, read_lo, read_hi, coils, duty_a, duty_b, pwm_prescale,
		       fast_step_period, step_timer_on, steps_left,
		output ready
	);
endinterface

// ===== design/mdrb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
// data, used for the coil-pattern table. Depends on nothing.
module mdrb_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/motor_driver_register_block.sv =====
// Top level of the motor driver register block. Depends on mdrb_pkg,
// mdrb_cmd_if, mdrb_rsp_if and mdrb_ram.
//
// One request (bus write, bus read or step tick) is taken per clock cycle
// unless the result channel stalls, and each yields one result. An accepted
// request passes through the stage-one register and then the output register,
// which holds the result; the registered read of the pattern table RAM is why
// stage one is there. All register state is updated at the accepting edge; the
// table entry read by that request (a table read or a stepping tick) joins the
// result from the RAM as stage one moves on, and the entry of a stepping tick
// is forwarded into the coil bits that the next request starts from. The table
// needs no clearing pass after reset: one valid flag per entry, cleared by
// reset, makes an unwritten entry read as the half-step reset pattern.
// A second result may wait in the output register while a new request is
// accepted.
module motor_driver_register_block #(
	parameter int unsigned MAX_PATTERN = 128
) (
	input logic        clk,
	input logic        arst_n,
	mdrb_cmd_if.sink   cmd,
	mdrb_rsp_if.source rsp
);

	import mdrb_pkg::*;

	localparam int unsigned AW = $clog2(MAX_PATTERN);
	localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

	// Architectural state.
	logic [7:0]             dir_q;
	logic [7:0]             div_q;
	logic [15:0]            intv_q;
	logic [15:0]            pulses_q;
	logic [7:0]             tick_cnt_q;
	logic [LW-1:0]          len_q;
	logic [AW-1:0]          pos_q;
	logic                   pos_vld_q;
	logic [LW-1:0]          wcur_q;
	logic [LW-1:0]          rcur_q;
	logic                   timer_en_q;
	logic                   fast_q;
	logic [3:0]             coil_q;
	logic                   coil_pend_q;
	logic [7:0]             duty_a_q;
	logic [7:0]             duty_b_q;
	logic [2:0]             pre_q;
	logic [MAX_PATTERN-1:0] tbl_vld_q;

	// Next-state values.
	logic [7:0]    dir_d;
	logic [7:0]    div_d;
	logic [15:0]   intv_d;
	logic [15:0]   pulses_d;
	logic [7:0]    tick_cnt_d;
	logic [LW-1:0] len_d;
	logic [AW-1:0] pos_d;
	logic          pos_vld_d;
	logic [LW-1:0] wcur_d;
	logic [LW-1:0] rcur_d;
	logic          timer_en_d;
	logic          fast_d;
	logic [3:0]    coil_d;
	logic          coil_pend_d;
	logic [7:0]    duty_a_d;
	logic [7:0]    duty_b_d;
	logic [2:0]    pre_d;
	logic [7:0]    rlo_d;
	logic [7:0]    rhi_d;
	logic          rd_tab_d;
	logic          tbl_we;
	logic [AW-1:0] tbl_raddr;

	// Stage one: the request just accepted, with its table read in flight.
	logic          s1_vld_q;
	logic [7:0]    rlo_s1;
	logic [7:0]    rhi_s1;
	logic          rd_tab_s1;
	logic [AW-1:0] tab_addr_s1;
	logic          tab_vld_s1;

	// Output register.
	logic        out_vld_q;
	logic [7:0]  out_rlo_q;
	logic [7:0]  out_rhi_q;
	logic [3:0]  out_coils_q;
	logic [7:0]  out_duty_a_q;
	logic [7:0]  out_duty_b_q;
	logic [2:0]  out_pre_q;
	logic        out_fast_q;
	logic        out_timer_q;
	logic [15:0] out_steps_q;

	logic          accept;
	logic          s1_adv;
	logic [3:0]    ram_rdata;
	logic [3:0]    tab_data;
	logic [3:0]    coil_eff;
	logic [28:0]   intv_prod;
	logic [7:0]    intv_speed;
	logic [7:0]    speed_sel;
	logic [7:0]    tick_inc;
	logic [LW:0]   pos_inc;
	logic [LW:0]   len_ext;

	// Handshake: stage one moves on when the output register is free.
	assign s1_adv    = s1_vld_q && (!out_vld_q || rsp.ready);
	assign cmd.ready = !s1_vld_q || s1_adv;
	assign accept    = cmd.valid && cmd.ready;

	// Table data of the last table access; unwritten entries read as reset.
	assign tab_data = tab_vld_s1 ? ram_rdata : pattern_reset_at(8'(tab_addr_s1));
	assign coil_eff = coil_pend_q ? tab_data : coil_q;

	// Interval in units of 40, truncated to the 8-bit speed.
	assign intv_prod  = 29'(intv_q[15:DIV_PRE_SHIFT]) * 29'(DIV_RECIP);
	assign intv_speed = intv_prod[DIV_POST_SHIFT +: 8];
	assign speed_sel  = (intv_q != 16'd0) ? intv_speed : cmd.data_hi;

	assign tick_inc = tick_cnt_q + 8'd1;
	assign pos_inc  = (LW+1)'(pos_q) + (LW+1)'(1);
	assign len_ext  = (LW+1)'(len_q);

	// Next state and result of the offered request.
	always_comb begin
		dir_d       = dir_q;
		div_d       = div_q;
		intv_d      = intv_q;
		pulses_d    = pulses_q;
		tick_cnt_d  = tick_cnt_q;
		len_d       = len_q;
		pos_d       = pos_q;
		pos_vld_d   = pos_vld_q;
		wcur_d      = wcur_q;
		rcur_d      = rcur_q;
		timer_en_d  = timer_en_q;
		fast_d      = fast_q;
		coil_d      = coil_eff;
		coil_pend_d = 1'b0;
		duty_a_d    = duty_a_q;
		duty_b_d    = duty_b_q;
		pre_d       = pre_q;
		rlo_d       = 8'd0;
		rhi_d       = 8'd0;
		rd_tab_d    = 1'b0;
		tbl_we      = 1'b0;
		tbl_raddr   = pos_q;

		case (cmd.kind)
			KIND_WRITE: begin
				case (cmd.reg_addr)
					ADDR_DUTY: begin
						duty_a_d = cmd.data_lo;
						duty_b_d = cmd.data_hi;
					end
					ADDR_PRESCALE: begin
						if (cmd.data_lo >= 8'(PRESCALE_MIN) && cmd.data_lo <= 8'(PRESCALE_MAX)) begin
							pre_d = cmd.data_lo[2:0];
						end else begin
							pre_d = PRESCALE_DEFAULT;
						end
					end
					ADDR_COIL_A: begin
						coil_d   = {coil_eff[3:2], cmd.data_lo[1:0]};
						duty_a_d = cmd.data_hi;
					end
					ADDR_COIL_B: begin
						coil_d   = {cmd.data_lo[1:0], coil_eff[1:0]};
						duty_b_d = cmd.data_hi;
					end
					ADDR_COIL_ALL: begin
						coil_d = cmd.data_lo[3:0];
					end
					ADDR_STEP_EN: begin
						dir_d      = cmd.data_lo;
						div_d      = (speed_sel == 8'd0) ? 8'd1 : speed_sel;
						timer_en_d = 1'b1;
						// On a first enable, anticlockwise stepping starts at the last entry.
						if (!pos_vld_q) begin
							if (cmd.data_lo == DIR_CCW && len_q != '0) begin
								pos_d = AW'(len_q - LW'(1));
							end else begin
								pos_d = '0;
							end
							pos_vld_d = 1'b1;
						end
						duty_a_d = DUTY_FULL;
						duty_b_d = DUTY_FULL;
					end
					ADDR_STEP_DIS: begin
						timer_en_d = 1'b0;
					end
					ADDR_STEPS: begin
						pulses_d = {cmd.data_hi, cmd.data_lo};
					end
					ADDR_INTERVAL: begin
						intv_d = {cmd.data_hi, cmd.data_lo};
						fast_d = ({cmd.data_hi, cmd.data_lo} != 16'd0);
					end
					ADDR_TBL_LEN: begin
						if ({1'b0, cmd.data_lo} > 9'(MAX_PATTERN)) begin
							len_d = LW'(MAX_PATTERN);
						end else begin
							len_d = LW'(cmd.data_lo);
						end
						wcur_d = '0;
					end
					ADDR_TBL_DATA: begin
						if (wcur_q < len_q) begin
							tbl_we = 1'b1;
							wcur_d = wcur_q + LW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			KIND_READ: begin
				case (cmd.reg_addr)
					ADDR_PID: begin
						rlo_d = PRODUCT_ID[7:0];
						rhi_d = PRODUCT_ID[15:8];
					end
					ADDR_VID: begin
						rlo_d = VENDOR_ID[7:0];
						rhi_d = VENDOR_ID[15:8];
					end
					ADDR_VERSION: begin
						rlo_d = FW_VERSION;
					end
					ADDR_STEP_EN: begin
						rlo_d = dir_q;
						rhi_d = div_q;
					end
					ADDR_STEPS: begin
						rlo_d = pulses_q[7:0];
						rhi_d = pulses_q[15:8];
					end
					ADDR_INTERVAL: begin
						rlo_d = intv_q[7:0];
						rhi_d = intv_q[15:8];
					end
					ADDR_TBL_LEN: begin
						rlo_d  = 8'(len_q);
						rcur_d = '0;
					end
					ADDR_TBL_DATA: begin
						tbl_raddr = rcur_q[AW-1:0];
						if (rcur_q < len_q) begin
							rd_tab_d = 1'b1;
							rcur_d   = rcur_q + LW'(1);
						end else begin
							rhi_d = 8'd1;
						end
					end
					default: begin
					end
				endcase
			end
			KIND_TICK: begin
				if (timer_en_q && pulses_q != 16'd0) begin
					if (tick_inc < div_q) begin
						tick_cnt_d = tick_inc;
					end else begin
						// One step: drive the current entry, then move.
						tick_cnt_d  = 8'd0;
						pulses_d    = pulses_q - 16'd1;
						pos_vld_d   = 1'b1;
						coil_pend_d = 1'b1;
						if (dir_q == DIR_CW) begin
							pos_d = (pos_inc >= len_ext) ? '0 : pos_inc[AW-1:0];
						end else if (dir_q == DIR_CCW) begin
							if (pos_q == '0) begin
								pos_d = (len_q != '0) ? AW'(len_q - LW'(1)) : '0;
							end else begin
								pos_d = pos_q - AW'(1);
							end
						end
					end
				end
			end
			default: begin
			end
		endcase

		// The tick counter clears whenever no steps are left.
		if (pulses_d == 16'd0) begin
			tick_cnt_d = 8'd0;
		end
	end

	// Register state, updated at each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= DIR_CW;
			div_q       <= DIVISOR_RESET;
			intv_q      <= 16'd0;
			pulses_q    <= PULSES_RESET;
			tick_cnt_q  <= 8'd0;
			len_q       <= LW'(PATTERN_LEN_RESET);
			pos_q       <= '0;
			pos_vld_q   <= 1'b0;
			wcur_q      <= '0;
			rcur_q      <= '0;
			timer_en_q  <= 1'b0;
			fast_q      <= 1'b0;
			coil_q      <= COIL_RESET;
			coil_pend_q <= 1'b0;
			duty_a_q    <= 8'd0;
			duty_b_q    <= 8'd0;
			pre_q       <= PRESCALE_DEFAULT;
			tbl_vld_q   <= '0;
		end else if (accept) begin
			dir_q       <= dir_d;
			div_q       <= div_d;
			intv_q      <= intv_d;
			pulses_q    <= pulses_d;
			tick_cnt_q  <= tick_cnt_d;
			len_q       <= len_d;
			pos_q       <= pos_d;
			pos_vld_q   <= pos_vld_d;
			wcur_q      <= wcur_d;
			rcur_q      <= rcur_d;
			timer_en_q  <= timer_en_d;
			fast_q      <= fast_d;
			coil_q      <= coil_d;
			coil_pend_q <= coil_pend_d;
			duty_a_q    <= duty_a_d;
			duty_b_q    <= duty_b_d;
			pre_q       <= pre_d;
			if (tbl_we) begin
				tbl_vld_q[wcur_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	// Coil-pattern table.
	mdrb_ram #(
		.WIDTH(4),
		.DEPTH(MAX_PATTERN)
	) u_tbl (
		.clk   (clk),
		.we    (accept && tbl_we),
		.waddr (wcur_q[AW-1:0]),
		.wdata (cmd.data_lo[3:0]),
		.re    (accept),
		.raddr (tbl_raddr),
		.rdata (ram_rdata)
	);

	// Stage-one and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Stage-one payload, captured with the table read.
	always_ff @(posedge clk) begin
		if (accept) begin
			rlo_s1      <= rlo_d;
			rhi_s1      <= rhi_d;
			rd_tab_s1   <= rd_tab_d;
			tab_addr_s1 <= tbl_raddr;
			tab_vld_s1  <= tbl_vld_q[tbl_raddr];
		end
	end

	// Output payload: stage one's read data and the settings it left.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_rlo_q    <= rd_tab_s1 ? {4'd0, tab_data} : rlo_s1;
			out_rhi_q    <= rhi_s1;
			out_coils_q  <= coil_eff;
			out_duty_a_q <= duty_a_q;
			out_duty_b_q <= duty_b_q;
			out_pre_q    <= pre_q;
			out_fast_q   <= fast_q;
			out_timer_q  <= timer_en_q;
			out_steps_q  <= pulses_q;
		end
	end

	assign rsp.valid            = out_vld_q;
	assign rsp.read_lo          = out_rlo_q;
	assign rsp.read_hi          = out_rhi_q;
	assign rsp.coils            = out_coils_q;
	assign rsp.duty_a           = out_duty_a_q;
	assign rsp.duty_b           = out_duty_b_q;
	assign rsp.pwm_prescale     = out_pre_q;
	assign rsp.fast_step_period = out_fast_q;
	assign rsp.step_timer_on    = out_timer_q;
	assign rsp.steps_left       = out_steps_q;

	// No request is taken while both result stages are full and stalled.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && out_vld_q && !rsp.ready) |-> !cmd.ready)
		else $error("request accepted with both result stages full");

	// The table length never exceeds the table depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PATTERN))
		else $error("pattern length above table depth");

	// The write cursor never runs past the table length.
	a_wcur_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcur_q <= len_q)
		else $error("write cursor past pattern length");

	// With no steps left the tick counter rests at zero.
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pulses_q == 16'd0) |-> (tick_cnt_q == 8'd0))
		else $error("tick counter running with no steps left");

endmodule

// ===== test/motor_driver_register_block_tb.sv =====
// Self-checking testbench of motor_driver_register_block: directed and random
// bus writes, reads and step ticks, each result checked against a local model.
// Depends on mdrb_pkg, mdrb_cmd_if, mdrb_rsp_if and the block itself.
module motor_driver_register_block_tb;
	import mdrb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PATTERN_MAX = 128;
	localparam logic [1:0]  KIND_NOP = 2'd3;
	localparam logic [15:0] INTERVAL_UNIT = 16'd40;
	localparam int          RANDOM_PER_PHASE = 300;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] addr;
		logic [7:0] lo;
		logic [7:0] hi;
	} request_t;

	typedef struct packed {
		logic [7:0]  read_lo;
		logic [7:0]  read_hi;
		logic [3:0]  coils;
		logic [7:0]  duty_a;
		logic [7:0]  duty_b;
		logic [2:0]  prescale;
		logic        fast_tick;
		logic        timer_on;
		logic [15:0] steps;
	} drive_status_t;

	logic clk;
	logic arst_n;

	mdrb_cmd_if cmd_ch ();
	mdrb_rsp_if rsp_ch ();

	motor_driver_register_block #(
		.MAX_PATTERN(PATTERN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	request_t      pending_requests[$];
	drive_status_t expected_status[$];
	int            mismatch_count;
	int unsigned   send_idle_pct;
	int unsigned   recv_stall_pct;

	// Local copy of the register block state.
	logic [7:0]  stepper_dir;
	logic [7:0]  step_divisor;
	logic [15:0] interval_val;
	logic [15:0] steps_val;
	logic [7:0]  tick_cnt;
	logic [7:0]  pat_len;
	logic [3:0]  pattern_mem [PATTERN_MAX];
	logic [6:0]  pat_pos;
	logic        pat_pos_set;
	logic [7:0]  wr_cursor;
	logic [7:0]  rd_cursor;
	logic        timer_on;
	logic        fast_tick;
	logic [3:0]  coil_state;
	logic [7:0]  duty_a_val;
	logic [7:0]  duty_b_val;
	logic [2:0]  prescale_val;

	task automatic reset_drive_state();
		stepper_dir = DIR_CW;
		step_divisor = DIVISOR_RESET;
		interval_val = '0;
		steps_val = PULSES_RESET;
		tick_cnt = '0;
		pat_len = PATTERN_LEN_RESET;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pattern_mem[i] = (i < 8) ? HALF_STEP[i] : 4'h0;
		end
		pat_pos = '0;
		pat_pos_set = 1'b0;
		wr_cursor = '0;
		rd_cursor = '0;
		timer_on = 1'b0;
		fast_tick = 1'b0;
		coil_state = COIL_RESET;
		duty_a_val = '0;
		duty_b_val = '0;
		prescale_val = PRESCALE_DEFAULT;
	endtask

	// Apply one request to the local state and return the status it leaves.
	function automatic drive_status_t apply_request(input request_t req);
		drive_status_t st;
		logic [15:0]   quotient;
		st = '0;
		case (req.kind)
			KIND_WRITE: begin
				case (req.addr)
					ADDR_DUTY: begin
						duty_a_val = req.lo;
						duty_b_val = req.hi;
					end
					ADDR_PRESCALE: begin
						if (req.lo >= PRESCALE_MIN && req.lo <= PRESCALE_MAX) begin
							prescale_val = req.lo[2:0];
						end else begin
							prescale_val = PRESCALE_DEFAULT;
						end
					end
					ADDR_COIL_A: begin
						coil_state = {coil_state[3:2], req.lo[1:0]};
						duty_a_val = req.hi;
					end
					ADDR_COIL_B: begin
						coil_state = {req.lo[1:0], coil_state[1:0]};
						duty_b_val = req.hi;
					end
					ADDR_COIL_ALL: begin
						coil_state = req.lo[3:0];
					end
					ADDR_STEP_EN: begin
						stepper_dir = req.lo;
						quotient = (interval_val != 0) ? interval_val / INTERVAL_UNIT
							: {8'd0, req.hi};
						step_divisor = (quotient[7:0] == 0) ? 8'd1 : quotient[7:0];
						timer_on = 1'b1;
						// A first enable picks the start entry from the direction.
						if (!pat_pos_set) begin
							if (stepper_dir == DIR_CCW && pat_len > 0) begin
								pat_pos = 7'(pat_len - 8'd1);
							end else begin
								pat_pos = '0;
							end
							pat_pos_set = 1'b1;
						end
						duty_a_val = DUTY_FULL;
						duty_b_val = DUTY_FULL;
					end
					ADDR_STEP_DIS: begin
						timer_on = 1'b0;
					end
					ADDR_STEPS: begin
						steps_val = {req.hi, req.lo};
					end
					ADDR_INTERVAL: begin
						interval_val = {req.hi, req.lo};
						fast_tick = (interval_val != 0);
					end
					ADDR_TBL_LEN: begin
						pat_len = (req.lo > PATTERN_MAX) ? 8'(PATTERN_MAX) : req.lo;
						wr_cursor = '0;
					end
					ADDR_TBL_DATA: begin
						if (wr_cursor < pat_len && wr_cursor < PATTERN_MAX) begin
							pattern_mem[wr_cursor[6:0]] = req.lo[3:0];
							wr_cursor = wr_cursor + 8'd1;
						end
					end
					default: begin
					end
				endcase
			end
			KIND_READ: begin
				case (req.addr)
					ADDR_PID:     {st.read_hi, st.read_lo} = PRODUCT_ID;
					ADDR_VID:     {st.read_hi, st.read_lo} = VENDOR_ID;
					ADDR_VERSION: st.read_lo = FW_VERSION;
					ADDR_STEP_EN: begin
						st.read_lo = stepper_dir;
						st.read_hi = step_divisor;
					end
					ADDR_STEPS:    {st.read_hi, st.read_lo} = steps_val;
					ADDR_INTERVAL: {st.read_hi, st.read_lo} = interval_val;
					ADDR_TBL_LEN: begin
						st.read_lo = pat_len;
						rd_cursor = '0;
					end
					ADDR_TBL_DATA: begin
						// Past the end the cursor stays and the high byte flags it.
						if (rd_cursor < pat_len) begin
							st.read_lo = {4'h0, pattern_mem[rd_cursor[6:0]]};
							rd_cursor = rd_cursor + 8'd1;
						end else begin
							st.read_hi = 8'd1;
						end
					end
					default: begin
					end
				endcase
			end
			KIND_TICK: begin
				if (timer_on && steps_val != 0) begin
					tick_cnt = tick_cnt + 8'd1;
					if (tick_cnt >= step_divisor) begin
						tick_cnt = '0;
						steps_val = steps_val - 16'd1;
						if (!pat_pos_set) begin
							pat_pos = '0;
							pat_pos_set = 1'b1;
						end
						coil_state = pattern_mem[pat_pos];
						// Other direction codes hold the position.
						if (stepper_dir == DIR_CW) begin
							if (8'(pat_pos) + 8'd1 >= pat_len) begin
								pat_pos = '0;
							end else begin
								pat_pos = pat_pos + 7'd1;
							end
						end else if (stepper_dir == DIR_CCW) begin
							if (pat_pos == 0) begin
								pat_pos = (pat_len > 0) ? 7'(pat_len - 8'd1) : 7'd0;
							end else begin
								pat_pos = pat_pos - 7'd1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (steps_val == 0) begin
			tick_cnt = '0;
		end
		st.coils = coil_state;
		st.duty_a = duty_a_val;
		st.duty_b = duty_b_val;
		st.prescale = prescale_val;
		st.fast_tick = fast_tick;
		st.timer_on = timer_on;
		st.steps = steps_val;
		return st;
	endfunction

	// Random request, weighted toward sequences that load the table and step.
	function automatic request_t random_request();
		request_t    req;
		int unsigned pick;
		req.kind = KIND_TICK;
		req.addr = 8'($urandom);
		req.lo = 8'($urandom);
		req.hi = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			req.kind = KIND_TICK;
		end else if (pick < 45) begin
			req.kind = 2'($urandom_range(0, 3));
		end else if (pick < 75) begin
			req.kind = KIND_WRITE;
			case ($urandom_range(0, 19))
				0: req.addr = ADDR_DUTY;
				1: begin
					req.addr = ADDR_PRESCALE;
					if ($urandom_range(0, 3) != 0) begin
						req.lo = 8'($urandom_range(0, 7));
					end
				end
				2: req.addr = ADDR_COIL_A;
				3: req.addr = ADDR_COIL_B;
				4: req.addr = ADDR_COIL_ALL;
				5, 6: begin
					req.addr = ADDR_STEP_EN;
					pick = $urandom_range(0, 9);
					if (pick < 4) begin
						req.lo = DIR_CCW;
					end else if (pick < 8) begin
						req.lo = DIR_CW;
					end
					if ($urandom_range(0, 3) != 0) begin
						req.hi = 8'($urandom_range(0, 4));
					end
				end
				7: req.addr = ADDR_STEP_DIS;
				8, 9: begin
					req.addr = ADDR_STEPS;
					if ($urandom_range(0, 3) != 0) begin
						{req.hi, req.lo} = 16'($urandom_range(0, 40));
					end
				end
				10: begin
					req.addr = ADDR_INTERVAL;
					pick = $urandom_range(0, 9);
					if (pick < 5) begin
						{req.hi, req.lo} = 16'd0;
					end else if (pick < 8) begin
						{req.hi, req.lo} = 16'($urandom_range(0, 200));
					end
				end
				11, 12: begin
					req.addr = ADDR_TBL_LEN;
					pick = $urandom_range(0, 9);
					if (pick < 7) begin
						req.lo = 8'($urandom_range(0, 16));
					end else if (pick < 9) begin
						req.lo = 8'($urandom_range(120, 136));
					end
				end
				default: req.addr = ADDR_TBL_DATA;
			endcase
		end else begin
			req.kind = KIND_READ;
			case ($urandom_range(0, 9))
				0: req.addr = ADDR_PID;
				1: req.addr = ADDR_VID;
				2: req.addr = ADDR_VERSION;
				3: req.addr = ADDR_STEP_EN;
				4: req.addr = ADDR_STEPS;
				5: req.addr = ADDR_INTERVAL;
				6: req.addr = ADDR_TBL_LEN;
				default: req.addr = ADDR_TBL_DATA;
			endcase
		end
		return req;
	endfunction

	task automatic queue_request(input logic [1:0] kind, input logic [7:0] addr,
			input logic [7:0] lo, input logic [7:0] hi);
		request_t req;
		req.kind = kind;
		req.addr = addr;
		req.lo = lo;
		req.hi = hi;
		pending_requests.push_back(req);
	endtask

	// Hold further stimulus until every request is taken and answered.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || cmd_ch.valid || expected_status.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Request driver: takes the next pending request once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		request_t      req;
		drive_status_t st;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.kind <= KIND_WRITE;
			cmd_ch.reg_addr <= '0;
			cmd_ch.data_lo <= '0;
			cmd_ch.data_hi <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				req = {cmd_ch.kind, cmd_ch.reg_addr, cmd_ch.data_lo, cmd_ch.data_hi};
				st = apply_request(req);
				expected_status.push_back(st);
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req = pending_requests.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.kind <= req.kind;
					cmd_ch.reg_addr <= req.addr;
					cmd_ch.data_lo <= req.lo;
					cmd_ch.data_hi <= req.hi;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		drive_status_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_status.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no request outstanding, expected none, actual steps %0h",
						$time, rsp_ch.steps_left);
				end else begin
					want = expected_status.pop_front();
					check_field("read_lo", 16'(want.read_lo), 16'(rsp_ch.read_lo));
					check_field("read_hi", 16'(want.read_hi), 16'(rsp_ch.read_hi));
					check_field("coils", 16'(want.coils), 16'(rsp_ch.coils));
					check_field("duty_a", 16'(want.duty_a), 16'(rsp_ch.duty_a));
					check_field("duty_b", 16'(want.duty_b), 16'(rsp_ch.duty_b));
					check_field("pwm_prescale", 16'(want.prescale), 16'(rsp_ch.pwm_prescale));
					check_field("fast_step_period", 16'(want.fast_tick),
						16'(rsp_ch.fast_step_period));
					check_field("step_timer_on", 16'(want.timer_on), 16'(rsp_ch.step_timer_on));
					check_field("steps_left", want.steps, rsp_ch.steps_left);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stimulus: reset, directed requests, then random phases with varied idling.
	initial begin
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		reset_drive_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Identification reads and the first table entry.
		queue_request(KIND_READ, ADDR_PID, 8'h00, 8'h00);
		queue_request(KIND_READ, ADDR_VID, 8'h00, 8'h00);
		queue_request(KIND_READ, ADDR_VERSION, 8'h00, 8'h00);
		queue_request(KIND_READ, ADDR_TBL_LEN, 8'h00, 8'h00);
		queue_request(KIND_READ, ADDR_TBL_DATA, 8'h00, 8'h00);
		// Interval of 120 gives a divisor of 3; anticlockwise starts at the last entry.
		queue_request(KIND_WRITE, ADDR_INTERVAL, 8'd120, 8'h00);
		queue_request(KIND_WRITE, ADDR_STEP_EN, DIR_CCW, 8'h00);
		queue_request(KIND_READ, ADDR_STEP_EN, 8'h00, 8'h00);
		queue_request(KIND_WRITE, ADDR_STEPS, 8'd2, 8'h00);
		// Two steps, then ticks with no steps left.
		repeat (7) queue_request(KIND_TICK, 8'h00, 8'h00, 8'h00);
		// Prescaler out of range, then the top code.
		queue_request(KIND_WRITE, ADDR_PRESCALE, 8'h07, 8'h00);
		queue_request(KIND_WRITE, ADDR_PRESCALE, 8'h05, 8'h00);
		queue_request(KIND_WRITE, ADDR_COIL_A, 8'hFF, 8'h5A);
		queue_request(KIND_WRITE, ADDR_COIL_B, 8'h02, 8'hA5);
		queue_request(KIND_WRITE, ADDR_COIL_ALL, 8'hF0, 8'hFF);
		// Oversized table length clamps; an empty table reads past the end.
		queue_request(KIND_WRITE, ADDR_TBL_LEN, 8'hFF, 8'h00);
		queue_request(KIND_READ, ADDR_TBL_LEN, 8'h00, 8'h00);
		queue_request(KIND_WRITE, ADDR_TBL_LEN, 8'h00, 8'h00);
		queue_request(KIND_READ, ADDR_TBL_DATA, 8'h00, 8'h00);
		queue_request(KIND_WRITE, ADDR_TBL_DATA, 8'h0F, 8'h00);
		// Odd direction with zero speed, stepping on an empty table.
		queue_request(KIND_WRITE, ADDR_INTERVAL, 8'h00, 8'h00);
		queue_request(KIND_WRITE, ADDR_STEP_EN, 8'hFE, 8'h00);
		queue_request(KIND_WRITE, ADDR_STEPS, 8'hFF, 8'hFF);
		queue_request(KIND_TICK, 8'h00, 8'h00, 8'h00);
		// No-op kind, unknown addresses, and disable.
		queue_request(KIND_NOP, 8'hFF, 8'hFF, 8'hFF);
		queue_request(KIND_WRITE, 8'h55, 8'hAA, 8'h55);
		queue_request(KIND_READ, 8'hFF, 8'h00, 8'h00);
		queue_request(KIND_WRITE, ADDR_STEP_DIS, 8'h00, 8'h00);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 57;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
			wait_drained();
		end

		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_status.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Run limit, well beyond the slowest legal run.
	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/mdrb_pkg.sv
design/mdrb_cmd_if.sv
design/mdrb_rsp_if.sv
design/mdrb_ram.sv
design/motor_driver_register_block.sv
test/motor_driver_register_block_tb.sv
